FILE: hw/rtl/plid_pkg.sv
// shared types and constants for the positional list block
`default_nettype none

package plid_pkg;

   // default list capacity
   localparam int CAPACITY_DEF = 16;

   // field widths fixed by the interface
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int SLOT_W   = 5;

   // request modes
   typedef enum logic [1:0] {
      MODE_INS_FRONT = 2'd0,
      MODE_INS_POS   = 2'd1,
      MODE_DELETE    = 2'd2,
      MODE_DUMP      = 2'd3
   } mode_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_OOB   = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   // request payload
   typedef struct packed {
      mode_type                   mode;
      logic signed [VALUE_W-1:0]  value;
      logic        [POS_W-1:0]    position;
   } req_type;

   // result payload
   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  element;
      logic        [SLOT_W-1:0]   slot;
      logic                       last;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/plid_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module plid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_insert_delete.sv
// Ordered list of signed 32-bit values with positional insert, delete and dump.
//
// Requests arrive on req_ (valid/ready) with a mode, a value and a 1-based
// position; results leave on rsp_ (valid/ready). Every edit (insert front,
// insert at position, delete at position) gives one result carrying a status
// with last set. A dump gives one result per element in list order, last set
// on the final one; a dump of an empty list gives a single empty status.
// One request is worked at a time and req_ready is low until it is finished.
// Elements live in a single ram; an edit moves them one entry per cycle
// through the ram read/write port pair, and a rejected edit moves none. A
// dump gives one result per cycle while the receiver does not stall. A
// finished result waits in an output register, and the next request is taken
// once it is there; when the receiver stalls, the block holds its next result
// until that register frees up. Reset (synchronous) empties the list at once;
// ram contents are not cleared and need not be.
`default_nettype none

module positional_list_insert_delete #(
   parameter int CAPACITY = plid_pkg::CAPACITY_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire plid_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output plid_pkg::rsp_type     rsp_data
);

   import plid_pkg::*;

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SHIFT = 4'b0010,
      ST_DUMP  = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               is_ins_ff, is_ins_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   status_type         status_ff, status_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      rd_left_ff, rd_left_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      rd_addr_q_ff, rd_addr_q_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [VALUE_W-1:0] ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [VALUE_W-1:0] ram_rdata;

   logic [CMPW-1:0]    pos_w;
   logic [CMPW-1:0]    cnt_w;
   logic               full;
   logic               empty;
   logic               ins_oob;
   logic               del_oob;
   logic [AW-1:0]      pos_idx;
   logic [AW-1:0]      ins_idx;
   logic               ins_bad;
   logic               out_free;
   logic [AW:0]        slot_full;
   logic               dump_last;

   // element storage
   plid_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // request checks against the current count
   assign pos_w   = CMPW'(req_data.position);
   assign cnt_w   = CMPW'(cnt_ff);
   assign full    = (cnt_w == CMPW'(CAPACITY));
   assign empty   = (cnt_ff == '0);
   assign ins_oob = (pos_w == '0) || (pos_w > (cnt_w + CMPW'(1)));
   assign del_oob = (pos_w == '0) || (pos_w > cnt_w);
   assign pos_idx = AW'(pos_w - CMPW'(1));
   assign ins_idx = (req_data.mode == MODE_INS_FRONT) ? '0 : pos_idx;
   assign ins_bad = (req_data.mode == MODE_INS_POS) && ins_oob;

   // dump position and end of list
   assign slot_full = (AW+1)'(rd_ptr_ff) + (AW+1)'(1);
   assign dump_last = (CMPW'(slot_full) == cnt_w);

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      is_ins_in    = is_ins_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_left_in   = rd_left_ff;
      pend_in      = 1'b0;
      rd_addr_q_in = rd_addr_q_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = rd_addr_q_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = rd_ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.mode)
                  MODE_INS_FRONT, MODE_INS_POS: begin
                     if (ins_bad) begin
                        status_in = STAT_OOB;
                        state_in  = ST_RESP;
                     end else if (full) begin
                        status_in = STAT_FULL;
                        state_in  = ST_RESP;
                     end else begin
                        // move entries idx..count-1 up by one, top first
                        is_ins_in  = 1'b1;
                        idx_in     = ins_idx;
                        value_in   = req_data.value;
                        rd_ptr_in  = AW'(cnt_ff - CW'(1));
                        rd_left_in = cnt_ff - CW'(ins_idx);
                        status_in  = STAT_OK;
                        state_in   = ST_SHIFT;
                     end
                  end
                  MODE_DELETE: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                        state_in  = ST_RESP;
                     end else if (del_oob) begin
                        status_in = STAT_OOB;
                        state_in  = ST_RESP;
                     end else begin
                        // move entries idx+1..count-1 down by one
                        is_ins_in  = 1'b0;
                        idx_in     = pos_idx;
                        rd_ptr_in  = AW'(pos_w);
                        rd_left_in = cnt_ff - CW'(pos_idx) - CW'(1);
                        status_in  = STAT_OK;
                        state_in   = ST_SHIFT;
                     end
                  end
                  MODE_DUMP: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                        state_in  = ST_RESP;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        rd_ptr_in = '0;
                        state_in  = ST_DUMP;
                     end
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            // issue the next read of the move
            if (rd_left_ff != '0) begin
               ram_re       = 1'b1;
               ram_raddr    = rd_ptr_ff;
               rd_ptr_in    = is_ins_ff ? (rd_ptr_ff - AW'(1)) : (rd_ptr_ff + AW'(1));
               rd_left_in   = rd_left_ff - CW'(1);
               pend_in      = 1'b1;
               rd_addr_q_in = rd_ptr_ff;
            end
            // write back the entry read last cycle, or finish the edit
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = is_ins_ff ? (rd_addr_q_ff + AW'(1)) : (rd_addr_q_ff - AW'(1));
               ram_wdata = ram_rdata;
            end else if (rd_left_ff == '0) begin
               if (is_ins_ff) begin
                  ram_we    = 1'b1;
                  ram_waddr = idx_ff;
                  ram_wdata = value_ff;
                  cnt_in    = cnt_ff + CW'(1);
               end else begin
                  cnt_in    = cnt_ff - CW'(1);
               end
               state_in = ST_RESP;
            end
         end

         ST_DUMP: begin
            // one element per free output slot, next read issued alongside
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.status  = STAT_OK;
               rsp_data_in.element = signed'(ram_rdata);
               rsp_data_in.slot    = SLOT_W'(slot_full);
               rsp_data_in.last    = dump_last;
               if (dump_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = rd_ptr_ff + AW'(1);
                  rd_ptr_in = rd_ptr_ff + AW'(1);
               end
            end
         end

         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.status  = status_ff;
               rsp_data_in.element = '0;
               rsp_data_in.slot    = '0;
               rsp_data_in.last    = 1'b1;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      is_ins_ff    <= is_ins_in;
      idx_ff       <= idx_in;
      value_ff     <= value_in;
      status_ff    <= status_in;
      rd_ptr_ff    <= rd_ptr_in;
      rd_left_ff   <= rd_left_in;
      rd_addr_q_ff <= rd_addr_q_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      CW'(cnt_ff) <= CW'(CAPACITY))
      else $error("list count above capacity");

   // count moves by one, and only at the end of a move sequence
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |->
         ($past(state_ff == ST_SHIFT) &&
          ((cnt_ff == $past(cnt_ff) + CW'(1)) || (cnt_ff == $past(cnt_ff) - CW'(1)))))
      else $error("list count changed outside a move");

   // a non-ok result is always a lone, empty result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != STAT_OK)) |->
         (rsp_data_ff.last && (rsp_data_ff.element == '0) && (rsp_data_ff.slot == '0)))
      else $error("error status result carries element data");

   // no ram write while a dump is running
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> !ram_we)
      else $error("ram written during dump");
`endif

endmodule

`default_nettype wire
